[design/plsc_pkg.sv]
// shared widths, register indexes and pipeline sideband for the setpoint correction block
`default_nettype none

package plsc_pkg;

    localparam int TGT_W       = 20;
    localparam int PT_W        = 16;
    localparam int SEG_W       = 3;
    localparam int CNT_W       = 4;
    localparam int PAIR_W      = 64;
    localparam int PAIR_NUM    = 4;
    localparam int PT_NUM      = 2 * PAIR_NUM;
    localparam int CFG_IDX_W   = 3;
    localparam int MAX_POINTS_DEF = 8;

    // differences, product and divider widths
    localparam int DX_W   = TGT_W + 1;
    localparam int DY_W   = PT_W + 1;
    localparam int PROD_W = DX_W + DY_W;
    localparam int NUM_W  = PROD_W - 2;
    localparam int DEN_W  = PT_W;
    localparam int MEAS_W = PROD_W;
    localparam int RES_W  = MEAS_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_POINT_PAIR_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_PAIR_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_PAIR_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_PAIR_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT  = 3'd4;

    typedef struct packed {
        logic [TGT_W-1:0] target;
        logic [PT_W-1:0]  meas_lo;
        logic [SEG_W-1:0] seg;
        logic             pass;
        logic             neg;
    } side_t;

endpackage

`default_nettype wire

[design/plsc_div.sv]
// pipelined restoring divider, one quotient bit per stage, sideband carried alongside
`default_nettype none

module plsc_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      ce,
    input  wire logic                      in_valid,
    input  wire logic [plsc_pkg::NUM_W-1:0] in_num,
    input  wire logic [plsc_pkg::DEN_W-1:0] in_den,
    input  wire plsc_pkg::side_t           in_side,
    output logic                           out_valid,
    output logic [plsc_pkg::NUM_W-1:0]     out_quo,
    output plsc_pkg::side_t                out_side
);
    import plsc_pkg::*;

    logic              valid_reg [NUM_W];
    logic [DEN_W-1:0]  rem_reg   [NUM_W];
    logic [NUM_W-1:0]  nq_reg    [NUM_W];
    logic [DEN_W-1:0]  den_reg   [NUM_W];
    side_t             side_reg  [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic             v_prev;
        logic [DEN_W-1:0] rem_prev;
        logic [NUM_W-1:0] nq_prev;
        logic [DEN_W-1:0] den_prev;
        side_t            side_prev;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             take;

        if (k == 0) begin : g_first
            assign v_prev    = in_valid;
            assign rem_prev  = '0;
            assign nq_prev   = in_num;
            assign den_prev  = in_den;
            assign side_prev = in_side;
        end else begin : g_rest
            assign v_prev    = valid_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign nq_prev   = nq_reg[k-1];
            assign den_prev  = den_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        assign trial = {rem_prev, nq_prev[NUM_W-1]};
        assign diff  = trial - {1'b0, den_prev};
        assign take  = (trial >= {1'b0, den_prev});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (ce) begin
                valid_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k]  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                nq_reg[k]   <= {nq_prev[NUM_W-2:0], take};
                den_reg[k]  <= den_prev;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[NUM_W-1];
    assign out_quo   = nq_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];

endmodule

`default_nettype wire

[design/piecewise_linear_setpoint_correction.sv]
// top level: calibration registers, segment search, interpolation pipeline and output register
//
// Corrects a current setpoint (1/16 mA) against up to eight (set, measured) calibration
// points: the measured value is interpolated on the segment that holds the target
// (end segments extrapolated) and the result is 2*target minus it, saturated to 20 bits.
// Fewer than two points or a zero-width segment return the target with passed_through
// set. The block takes one request per cycle while the output is not held; a request
// passes through search, select, multiply, magnitude, the 36-stage divider (one quotient
// bit per stage) and two output stages. The whole pipeline advances together and
// holds while a result waits at the output. Configuration writes are always ready and
// must happen only while no request is in flight.
`default_nettype none

module piecewise_linear_setpoint_correction #(
    parameter int MAX_POINTS = plsc_pkg::MAX_POINTS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [plsc_pkg::TGT_W-1:0]     s_target_current,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [plsc_pkg::TGT_W-1:0]         m_corrected_current,
    output logic                               m_saturated,
    output logic                               m_passed_through,
    output logic [plsc_pkg::SEG_W-1:0]         m_segment_used,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [plsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [plsc_pkg::PAIR_W-1:0]    cfg_data
);
    import plsc_pkg::*;

    localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_POINTS);

    // configuration
    logic [PAIR_W-1:0] pair_reg [PAIR_NUM];
    logic [CNT_W-1:0]  count_reg;
    logic [PT_W-1:0]   set_pt  [PT_NUM];
    logic [PT_W-1:0]   meas_pt [PT_NUM];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < PAIR_NUM; p++) begin
                pair_reg[p] <= '0;
            end
            count_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_POINT_PAIR_0: pair_reg[0] <= cfg_data;
                REG_POINT_PAIR_1: pair_reg[1] <= cfg_data;
                REG_POINT_PAIR_2: pair_reg[2] <= cfg_data;
                REG_POINT_PAIR_3: pair_reg[3] <= cfg_data;
                REG_POINT_COUNT:  count_reg   <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int p = 0; p < PAIR_NUM; p++) begin
            set_pt[2*p]    = pair_reg[p][15:0];
            meas_pt[2*p]   = pair_reg[p][31:16];
            set_pt[2*p+1]  = pair_reg[p][47:32];
            meas_pt[2*p+1] = pair_reg[p][63:48];
        end
    end

    // pipeline advance
    logic ce;
    assign ce      = !m_valid || m_ready;
    assign s_ready = ce;

    // stage 1: segment search
    logic             v1_reg;
    logic [TGT_W-1:0] t1_reg;
    logic [SEG_W-1:0] seg1_reg;
    logic             pass1_reg;
    logic [CNT_W-1:0] n_cnt;
    logic [SEG_W-1:0] seg1_next;
    logic             pass1_next;

    always_comb begin
        n_cnt      = (count_reg > MAX_N) ? MAX_N : count_reg;
        pass1_next = (n_cnt < CNT_W'(2));
        seg1_next  = SEG_W'(n_cnt - CNT_W'(2));
        for (int k = MAX_POINTS - 2; k >= 0; k--) begin
            if ((CNT_W'(k + 1) < n_cnt) && (s_target_current <= {set_pt[k+1], 4'b0000})) begin
                seg1_next = SEG_W'(k);
            end
        end
        if (pass1_next) begin
            seg1_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            t1_reg    <= s_target_current;
            seg1_reg  <= seg1_next;
            pass1_reg <= pass1_next;
        end
    end

    // stage 2: point select and differences
    logic                   v2_reg;
    logic [TGT_W-1:0]       t2_reg;
    logic [PT_W-1:0]        y0_2_reg;
    logic [SEG_W-1:0]       seg2_reg;
    logic                   pass2_reg;
    logic signed [DX_W-1:0] dx2_reg;
    logic signed [DY_W-1:0] dy2_reg;
    logic signed [DY_W-1:0] dw2_reg;
    logic [PT_W-1:0]        x0_sel, x1_sel, y0_sel, y1_sel;

    always_comb begin
        x0_sel = '0;
        x1_sel = '0;
        y0_sel = '0;
        y1_sel = '0;
        for (int k = 0; k < PT_NUM - 1; k++) begin
            if (seg1_reg == SEG_W'(k)) begin
                x0_sel = set_pt[k];
                x1_sel = set_pt[k+1];
                y0_sel = meas_pt[k];
                y1_sel = meas_pt[k+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (ce) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            t2_reg    <= t1_reg;
            y0_2_reg  <= y0_sel;
            seg2_reg  <= seg1_reg;
            pass2_reg <= pass1_reg || (x1_sel == x0_sel);
            dx2_reg   <= $signed({1'b0, t1_reg}) - $signed({1'b0, x0_sel, 4'b0000});
            dy2_reg   <= $signed({1'b0, y1_sel}) - $signed({1'b0, y0_sel});
            dw2_reg   <= $signed({1'b0, x1_sel}) - $signed({1'b0, x0_sel});
        end
    end

    // stage 3: product
    logic                     v3_reg;
    side_t                    side3_reg;
    logic signed [PROD_W-1:0] prod3_reg;
    logic signed [DY_W-1:0]   dw3_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = dx2_reg * dy2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (ce) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            prod3_reg         <= prod_next;
            dw3_reg           <= dw2_reg;
            side3_reg.target  <= t2_reg;
            side3_reg.meas_lo <= y0_2_reg;
            side3_reg.seg     <= seg2_reg;
            side3_reg.pass    <= pass2_reg;
            side3_reg.neg     <= 1'b0;
        end
    end

    // stage 4: magnitudes and quotient sign
    logic                     v4_reg;
    side_t                    side4_reg;
    side_t                    side4_next;
    logic [NUM_W-1:0]         num4_reg;
    logic [DEN_W-1:0]         den4_reg;
    logic signed [PROD_W-1:0] prod_neg;
    logic signed [DY_W-1:0]   dw_neg;

    assign prod_neg = -prod3_reg;
    assign dw_neg   = -dw3_reg;

    always_comb begin
        side4_next     = side3_reg;
        side4_next.neg = prod3_reg[PROD_W-1] ^ dw3_reg[DY_W-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (ce) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            num4_reg  <= prod3_reg[PROD_W-1] ? prod_neg[NUM_W-1:0] : prod3_reg[NUM_W-1:0];
            den4_reg  <= dw3_reg[DY_W-1] ? dw_neg[DEN_W-1:0] : dw3_reg[DEN_W-1:0];
            side4_reg <= side4_next;
        end
    end

    // divider
    logic             div_valid;
    logic [NUM_W-1:0] div_quo;
    side_t            div_side;

    plsc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (v4_reg),
        .in_num    (num4_reg),
        .in_den    (den4_reg),
        .in_side   (side4_reg),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_side  (div_side)
    );

    // stage 5: interpolated measurement
    logic                     v5_reg;
    side_t                    side5_reg;
    logic signed [MEAS_W-1:0] meas5_reg;
    logic signed [MEAS_W-1:0] q_pos;
    logic signed [MEAS_W-1:0] q_sgn;

    assign q_pos = $signed({2'b00, div_quo});
    assign q_sgn = div_side.neg ? -q_pos : q_pos;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (ce) begin
            v5_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            side5_reg <= div_side;
            meas5_reg <= $signed({{(MEAS_W-PT_W-4){1'b0}}, div_side.meas_lo, 4'b0000}) + q_sgn;
        end
    end

    // stage 6: correction, saturation, output register
    logic                    out_valid_reg;
    logic [TGT_W-1:0]        out_cur_reg;
    logic                    out_sat_reg;
    logic                    out_pass_reg;
    logic [SEG_W-1:0]        out_seg_reg;
    logic signed [RES_W-1:0] res;
    logic [TGT_W-1:0]        cur_next;
    logic                    sat_next;

    assign res = $signed({{(RES_W-TGT_W-1){1'b0}}, side5_reg.target, 1'b0})
               - $signed({meas5_reg[MEAS_W-1], meas5_reg});

    always_comb begin
        cur_next = res[TGT_W-1:0];
        sat_next = 1'b0;
        if (side5_reg.pass) begin
            cur_next = side5_reg.target;
        end else if (res[RES_W-1]) begin
            cur_next = '0;
            sat_next = 1'b1;
        end else if (|res[RES_W-2:TGT_W]) begin
            cur_next = '1;
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ce) begin
            out_valid_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_cur_reg  <= cur_next;
            out_sat_reg  <= sat_next;
            out_pass_reg <= side5_reg.pass;
            out_seg_reg  <= side5_reg.seg;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_corrected_current = out_cur_reg;
    assign m_saturated         = out_sat_reg;
    assign m_passed_through    = out_pass_reg;
    assign m_segment_used      = out_seg_reg;

endmodule

`default_nettype wire

[verif/piecewise_linear_setpoint_correction_tb.sv]
// testbench for the piecewise-linear setpoint correction block: directed and random checks
`timescale 1ns / 100ps

module piecewise_linear_setpoint_correction_tb;

    import plsc_pkg::*;

    localparam int POINT_LIMIT  = MAX_POINTS_DEF;
    localparam int TGT_MAX      = (1 << TGT_W) - 1;
    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 64;
    localparam int PHASE_COUNT  = 12;
    localparam int PHASE_ITEMS  = 120;
    localparam int MAX_PRINTS   = 40;

    typedef struct packed {
        logic [TGT_W-1:0] target;
        logic [TGT_W-1:0] corrected;
        logic             saturated;
        logic             passed_through;
        logic [SEG_W-1:0] segment;
    } correction_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [TGT_W-1:0]     s_target_current = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [TGT_W-1:0]     m_corrected_current;
    logic                 m_saturated;
    logic                 m_passed_through;
    logic [SEG_W-1:0]     m_segment_used;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PAIR_W-1:0]    cfg_data = '0;

    logic [PT_W-1:0]      cal_set [PT_NUM];
    logic [PT_W-1:0]      cal_meas [PT_NUM];
    logic [CNT_W-1:0]     cal_count;

    logic [TGT_W-1:0]     pending_targets [$];
    correction_t          expected_corrections [$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    logic hold_trigger = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    int mismatch_count = 0;
    int requests_sent = 0;
    int results_checked = 0;
    int settings_used = 0;
    int passthrough_seen = 0;
    int saturated_seen = 0;
    logic [PT_NUM-1:0] segments_seen = '0;

    piecewise_linear_setpoint_correction i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_target_current    (s_target_current),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_corrected_current (m_corrected_current),
        .m_saturated         (m_saturated),
        .m_passed_through    (m_passed_through),
        .m_segment_used      (m_segment_used),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic correction_t predict_correction(input logic [TGT_W-1:0] target);
        correction_t res;
        int n;
        int seg;
        longint t, x0, x1, y0, y1, q, r;
        res.target = target;
        res.corrected = target;
        res.saturated = 1'b0;
        res.passed_through = 1'b1;
        res.segment = '0;
        n = (cal_count > POINT_LIMIT) ? POINT_LIMIT : cal_count;
        if (n < 2) begin
            return res;
        end
        t = target;
        seg = n - 2;
        for (int k = 0; k + 1 < n; k++) begin
            if (t <= 16 * longint'(cal_set[k+1])) begin
                seg = k;
                break;
            end
        end
        res.segment = SEG_W'(seg);
        x0 = cal_set[seg];
        x1 = cal_set[seg+1];
        y0 = cal_meas[seg];
        y1 = cal_meas[seg+1];
        if (x1 == x0) begin
            return res;
        end
        q = ((t - 16 * x0) * (y1 - y0)) / (x1 - x0);
        r = 2 * t - (16 * y0 + q);
        res.passed_through = 1'b0;
        if (r < 0) begin
            r = 0;
            res.saturated = 1'b1;
        end else if (r > TGT_MAX) begin
            r = TGT_MAX;
            res.saturated = 1'b1;
        end
        res.corrected = r[TGT_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [TGT_W-1:0] target,
                                   input longint got, input longint want);
        if (mismatch_count < MAX_PRINTS) begin
            $display("%0t mismatch on %s for target %0d: got %0d, expected %0d",
                     $realtime, what, target, got, want);
        end
        mismatch_count++;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [PAIR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            REG_POINT_PAIR_0, REG_POINT_PAIR_1, REG_POINT_PAIR_2, REG_POINT_PAIR_3: begin
                cal_set[2*index]    = data[15:0];
                cal_meas[2*index]   = data[31:16];
                cal_set[2*index+1]  = data[47:32];
                cal_meas[2*index+1] = data[63:48];
            end
            REG_POINT_COUNT: begin
                cal_count = data[CNT_W-1:0];
                settings_used++;
            end
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_targets.size() != 0 || s_valid || expected_corrections.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic load_random_calibration(input bit well_formed);
        logic [PT_W-1:0] sets [PT_NUM];
        logic [PT_W-1:0] meas [PT_NUM];
        int pos;
        int spread;
        int m;
        int step;
        pos = $urandom_range(0, 3000);
        for (int k = 0; k < PT_NUM; k++) begin
            spread = pos / 10 + 50;
            m = pos + int'($urandom_range(0, 2 * spread)) - spread;
            m = (m < 0) ? 0 : (m > 65535) ? 65535 : m;
            sets[k] = PT_W'(pos);
            meas[k] = PT_W'(m);
            step = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 8000);
            pos = (pos + step > 65535) ? 65535 : pos + step;
        end
        for (int p = 0; p < PAIR_NUM; p++) begin
            write_register(CFG_IDX_W'(p), well_formed ?
                           {meas[2*p+1], sets[2*p+1], meas[2*p], sets[2*p]} :
                           {$urandom, $urandom});
        end
        write_register(REG_POINT_COUNT, well_formed ? PAIR_W'($urandom_range(2, PT_NUM)) :
                                                      PAIR_W'($urandom_range(0, 15)));
        if ($urandom_range(0, 3) == 0) begin
            write_register(CFG_IDX_W'(REG_POINT_COUNT + 1 + $urandom_range(0, 2)),
                           {$urandom, $urandom});
        end
    endtask

    task automatic queue_targets(input int num);
        int v;
        int k;
        repeat (num) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: v = $urandom_range(0, TGT_MAX);
                4, 5, 6, 7: begin
                    k = $urandom_range(0, PT_NUM - 1);
                    v = 16 * int'(cal_set[k]) + int'($urandom_range(0, 64)) - 32;
                    v = (v < 0) ? 0 : (v > TGT_MAX) ? TGT_MAX : v;
                end
                8: v = $urandom_range(0, 63);
                default: v = TGT_MAX - int'($urandom_range(0, 63));
            endcase
            pending_targets.push_back(TGT_W'(v));
        end
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_corrections.push_back(predict_correction(s_target_current));
                requests_sent++;
            end
            if (s_valid && !s_ready) begin
            end else if (pending_targets.size() != 0 &&
                         $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_target_current <= pending_targets.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_trigger) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        correction_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_corrections.size() == 0) begin
                    report_mismatch("result with no request", '0, m_corrected_current, 0);
                end else begin
                    want = expected_corrections.pop_front();
                    results_checked++;
                    if (want.passed_through) passthrough_seen++;
                    if (want.saturated) saturated_seen++;
                    segments_seen[want.segment] = 1'b1;
                    if (m_corrected_current !== want.corrected)
                        report_mismatch("corrected_current", want.target,
                                        m_corrected_current, want.corrected);
                    if (m_saturated !== want.saturated)
                        report_mismatch("saturated", want.target, m_saturated, want.saturated);
                    if (m_passed_through !== want.passed_through)
                        report_mismatch("passed_through", want.target,
                                        m_passed_through, want.passed_through);
                    if (m_segment_used !== want.segment)
                        report_mismatch("segment_used", want.target,
                                        m_segment_used, want.segment);
                end
            end
            m_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == IDLE_LIMIT) begin
            $display("timeout after %0d cycles with no request accepted", IDLE_LIMIT);
            $display("piecewise_linear_setpoint_correction_tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int k = 0; k < PT_NUM; k++) begin
            cal_set[k] = '0;
            cal_meas[k] = '0;
        end
        cal_count = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // no calibration after reset
        pending_targets.push_back(20'h00000);
        pending_targets.push_back(20'hFFFFF);
        pending_targets.push_back(20'h55555);
        wait_drained();

        // single point, unused index ignored
        write_register(REG_POINT_COUNT, 64'd1);
        write_register(CFG_IDX_W'(REG_POINT_COUNT + 1), '1);
        pending_targets.push_back(20'hAAAAA);
        wait_drained();

        // four points: extrapolation at both ends, exact points, both saturations
        write_register(REG_POINT_PAIR_0, {16'd220, 16'd200, 16'd2000, 16'd100});
        write_register(REG_POINT_PAIR_1, {16'd20000, 16'd60000, 16'd39000, 16'd40000});
        write_register(REG_POINT_COUNT, 64'd4);
        pending_targets.push_back(20'd0);
        pending_targets.push_back(20'd1600);
        pending_targets.push_back(20'd3200);
        pending_targets.push_back(20'd3201);
        pending_targets.push_back(20'd640000);
        pending_targets.push_back(20'd960000);
        pending_targets.push_back(20'hFFFFF);
        wait_drained();

        // zero-width last segment
        write_register(REG_POINT_PAIR_1, {16'd20000, 16'd40000, 16'd39000, 16'd40000});
        pending_targets.push_back(20'd640000);
        pending_targets.push_back(20'd640001);
        wait_drained();

        // points out of order, negative width with truncation
        write_register(REG_POINT_PAIR_0, {16'd100, 16'd50, 16'd200, 16'd300});
        write_register(REG_POINT_COUNT, 64'd2);
        pending_targets.push_back(20'd800);
        pending_targets.push_back(20'd1003);
        wait_drained();

        // all-ones table with count above the limit
        for (int p = 0; p < PAIR_NUM; p++) write_register(CFG_IDX_W'(p), '1);
        write_register(REG_POINT_COUNT, '1);
        pending_targets.push_back(20'd0);
        pending_targets.push_back(20'hFFFFF);
        wait_drained();

        // all-zero table, full count
        for (int p = 0; p < PAIR_NUM; p++) write_register(CFG_IDX_W'(p), '0);
        write_register(REG_POINT_COUNT, 64'd8);
        pending_targets.push_back(20'd0);
        pending_targets.push_back(20'd16);
        wait_drained();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 66; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 66; end
                default: begin send_idle_pct = 22; stall_pct = 22; end
            endcase
            load_random_calibration(phase % 3 != 2);
            if (phase == 4) begin
                send_idle_pct = 0;
                stall_pct = 0;
                hold_trigger <= 1'b1;
                @(posedge aclk);
                hold_trigger <= 1'b0;
            end
            queue_targets(PHASE_ITEMS);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("%0d requests checked against %0d results over %0d calibration settings",
                 requests_sent, results_checked, settings_used);
        $display("%0d passed through, %0d saturated, segments reached %b",
                 passthrough_seen, saturated_seen, segments_seen);
        if (mismatch_count == 0) begin
            $display("piecewise_linear_setpoint_correction_tb passed");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("piecewise_linear_setpoint_correction_tb failed");
        end
        $finish;
    end

endmodule
